>>> hdl/swre_pkg.sv
// Package with types, constants and codes shared by the receive engine files.
package swre_pkg;

    localparam int WINDOW_MAX_DEF = 32;
    localparam int PACKET_MAX_DEF = 512;

    localparam int WIN_W   = 6;
    localparam int LEN_W   = 10;
    localparam int FLEN_W  = 16;
    localparam int SPACE_W = 16;
    localparam int SLOT_W  = 5;
    localparam int PLEN_W  = 9;
    localparam int SEQ_W   = 32;

    localparam logic [WIN_W-1:0]  WINDOW_RESET = 6'd8;
    localparam logic [FLEN_W-1:0] ACK_LEN      = 16'd8;
    localparam logic [FLEN_W-1:0] HDR_LEN      = 16'd12;

    typedef enum logic [2:0] {
        KIND_REJECT     = 3'd0,
        KIND_ACK_OK     = 3'd1,
        KIND_ACK_DROP   = 3'd2,
        KIND_DUP        = 3'd3,
        KIND_STORED     = 3'd4,
        KIND_NOT_STORED = 3'd5,
        KIND_BEYOND     = 3'd6,
        KIND_DELIVER    = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        CLS_REJECT = 2'd0,
        CLS_ACK    = 2'd1,
        CLS_DATA   = 2'd2
    } cls_t;

    typedef struct packed {
        cls_t               cls;
        logic [SEQ_W-1:0]   seq;
        logic [SEQ_W-1:0]   ackno;
        logic [LEN_W-1:0]   len;
        logic [SPACE_W-1:0] space;
    } cmd_t;

    typedef struct packed {
        kind_t             kind;
        logic [SLOT_W-1:0] slot;
        logic [SEQ_W-1:0]  value;
        logic [PLEN_W-1:0] plen;
        logic              eof;
        logic              last;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DUPSCAN,
        ST_FREESCAN,
        ST_REL,
        ST_FLUSH
    } state_t;

endpackage

>>> hdl/swre_if.sv
// Channel interfaces for header items, result items and the window register write.
interface swre_rx_if;
    import swre_pkg::*;
    logic               valid;
    logic               ready;
    logic [FLEN_W-1:0]  received_length;
    logic [FLEN_W-1:0]  advertised_length;
    logic               checksum_ok;
    logic [SEQ_W-1:0]   sequence_number;
    logic [SEQ_W-1:0]   ack_number;
    logic [SPACE_W-1:0] output_space;
    modport source (output valid, received_length, advertised_length, checksum_ok,
                    sequence_number, ack_number, output_space, input ready);
    modport sink (input valid, received_length, advertised_length, checksum_ok,
                  sequence_number, ack_number, output_space, output ready);
endinterface

interface swre_tx_if;
    import swre_pkg::*;
    logic              valid;
    logic              ready;
    logic [2:0]        kind;
    logic [SLOT_W-1:0] slot;
    logic [SEQ_W-1:0]  value;
    logic [PLEN_W-1:0] payload_length;
    logic              end_of_file;
    logic              last;
    modport source (output valid, kind, slot, value, payload_length, end_of_file, last,
                    input ready);
    modport sink (input valid, kind, slot, value, payload_length, end_of_file, last,
                  output ready);
endinterface

interface swre_cfg_if;
    import swre_pkg::*;
    logic             valid;
    logic             ready;
    logic [WIN_W-1:0] window_size;
    modport source (output valid, window_size, input ready);
    modport sink (input valid, window_size, output ready);
endinterface

>>> hdl/swre_front.sv
// Front end: header check and classification of each incoming item.
module swre_front #(
    parameter int PACKET_MAX = swre_pkg::PACKET_MAX_DEF
) (
    swre_rx_if.sink        rx,
    input  logic           q_full,
    output logic           push,
    output swre_pkg::cmd_t cmd
);
    import swre_pkg::*;

    localparam logic [FLEN_W-1:0] PMAX = FLEN_W'(PACKET_MAX);

    logic hdr_ok;

    always_comb
    begin
        hdr_ok = (rx.received_length == rx.advertised_length) &&
                 (rx.advertised_length >= ACK_LEN) &&
                 (rx.advertised_length <= PMAX) &&
                 !((rx.advertised_length > ACK_LEN) && (rx.advertised_length < HDR_LEN)) &&
                 rx.checksum_ok;
        cmd.seq   = rx.sequence_number;
        cmd.ackno = rx.ack_number;
        cmd.len   = rx.advertised_length[LEN_W-1:0];
        cmd.space = rx.output_space;
        priority if (!hdr_ok)
            cmd.cls = CLS_REJECT;
        else if (rx.advertised_length == ACK_LEN)
            cmd.cls = CLS_ACK;
        else
            cmd.cls = CLS_DATA;
    end

    assign rx.ready = !q_full;
    assign push     = rx.valid && !q_full;

endmodule

>>> hdl/swre_queue.sv
// Two-entry command queue between the front end and the back end.
module swre_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  swre_pkg::cmd_t push_cmd,
    input  logic           pop,
    output swre_pkg::cmd_t head,
    output logic           not_empty,
    output logic           full,
    output logic [1:0]     count
);
    import swre_pkg::*;

    cmd_t       mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    assign head      = mem[rd_ptr_reg];
    assign not_empty = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign count     = count_reg;

endmodule

>>> hdl/swre_back.sv
// Back end: ack handling, slot buffer search and store, in-order release, result output.
module swre_back #(
    parameter int WINDOW_MAX = swre_pkg::WINDOW_MAX_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [swre_pkg::WIN_W-1:0] window_size,
    input  swre_pkg::cmd_t           head,
    input  logic                     q_valid,
    output logic                     pop,
    swre_tx_if.source                tx
);
    import swre_pkg::*;

    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int CMP_W = (CNT_W > WIN_W) ? CNT_W : WIN_W;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]   j_reg, i_reg;
    logic [SEQ_W-1:0]   seq_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [SPACE_W-1:0] space_reg;
    logic [SEQ_W-1:0]   acked_reg, deliv_reg;
    logic               eof_reg;
    logic [WINDOW_MAX-1:0] valid_reg;
    logic [SEQ_W-1:0]   seqno_mem [WINDOW_MAX];
    logic [LEN_W-1:0]   len_mem   [WINDOW_MAX];
    res_t               pend_reg;
    logic               tx_valid_reg;
    res_t               tx_reg;

    logic [CNT_W-1:0]   w;
    logic [IDX_W-1:0]   jx;
    logic               out_free, scan_end, hit_dup, slot_free, rel_hit, rel_full;
    logic               rel_emit, rel_adv, rel_end, flush;
    logic [SEQ_W-1:0]   ack_d;
    logic               ack_ok, is_dup, in_win;
    logic [LEN_W-1:0]   cur_len;
    logic [LEN_W-1:0]   cur_plen;
    res_t               idle_res, deliver_res, scan_res, tx_load;

    // Effective window: zero acts as one, clamped to the buffer depth.
    always_comb
    begin
        priority if (window_size == '0)
            w = CNT_W'(1);
        else if (CMP_W'(window_size) > CMP_W'(WINDOW_MAX))
            w = CNT_W'(WINDOW_MAX);
        else
            w = CNT_W'(window_size);
    end

    always_comb
    begin
        jx        = j_reg[IDX_W-1:0];
        out_free  = !tx_valid_reg || tx.ready;
        scan_end  = (j_reg == w);
        cur_len   = len_mem[jx];
        cur_plen  = (cur_len >= LEN_W'(HDR_LEN)) ? cur_len - LEN_W'(HDR_LEN) : '0;
        hit_dup   = valid_reg[jx] && (seqno_mem[jx] == seq_reg);
        slot_free = !valid_reg[jx];
        rel_hit   = valid_reg[jx] && (seqno_mem[jx] == deliv_reg + 32'd1);
        rel_full  = (space_reg <= SPACE_W'(cur_len));
        rel_end   = (i_reg == w);
        rel_emit  = (state_reg == ST_REL) && !rel_end && rel_hit && !rel_full && out_free;
        rel_adv   = (state_reg == ST_REL) && !rel_end && (!rel_hit || rel_emit);
        flush     = (state_reg == ST_FLUSH) && out_free;
        pop       = (state_reg == ST_IDLE) && q_valid;

        ack_d  = head.ackno - acked_reg - 32'd1;
        ack_ok = !ack_d[SEQ_W-1] && (ack_d <= SEQ_W'(w));
        is_dup = (head.seq <= deliv_reg);
        in_win = (head.seq <= deliv_reg + SEQ_W'(w));

        idle_res = '0;
        idle_res.kind = KIND_REJECT;
        unique case (head.cls)
            CLS_ACK:
            begin
                idle_res.kind  = ack_ok ? KIND_ACK_OK : KIND_ACK_DROP;
                idle_res.value = ack_ok ? head.ackno - 32'd1 : acked_reg;
            end
            CLS_DATA:
            begin
                if (is_dup)
                begin
                    idle_res.kind  = KIND_DUP;
                    idle_res.value = deliv_reg + 32'd1;
                end
                else
                    idle_res.kind = KIND_BEYOND;
            end
            default: idle_res.kind = KIND_REJECT;
        endcase

        deliver_res       = '0;
        deliver_res.kind  = KIND_DELIVER;
        deliver_res.slot  = SLOT_W'(jx);
        deliver_res.value = seqno_mem[jx] + 32'd1;
        deliver_res.plen  = cur_plen[PLEN_W-1:0];
        deliver_res.eof   = (cur_len == LEN_W'(HDR_LEN));

        // Search outcome: a free slot found stores the item; a repeat or no room does not.
        scan_res      = '0;
        scan_res.kind = (state_reg == ST_FREESCAN && !scan_end) ? KIND_STORED
                                                                : KIND_NOT_STORED;
        scan_res.slot = (state_reg == ST_FREESCAN && scan_end) ? '0 : SLOT_W'(jx);

        tx_load      = pend_reg;
        tx_load.last = flush;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (q_valid)
                    state_next = (head.cls == CLS_DATA && !is_dup && in_win) ?
                                 ST_DUPSCAN : ST_FLUSH;
            ST_DUPSCAN:
                priority if (scan_end)
                    state_next = ST_FREESCAN;
                else if (hit_dup)
                    state_next = eof_reg ? ST_FLUSH : ST_REL;
            ST_FREESCAN:
                if (scan_end || slot_free)
                    state_next = eof_reg ? ST_FLUSH : ST_REL;
            ST_REL:
                priority if (rel_end)
                    state_next = ST_FLUSH;
                else if (rel_hit && rel_full)
                    state_next = ST_FLUSH;
                else if (rel_emit && deliver_res.eof)
                    state_next = ST_FLUSH;
            ST_FLUSH:
                if (out_free)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            acked_reg      <= '0;
            deliv_reg      <= '0;
            eof_reg        <= 1'b0;
            valid_reg      <= '0;
            tx_valid_reg   <= 1'b0;
            j_reg          <= '0;
            i_reg          <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (rel_emit || flush)
                tx_valid_reg <= 1'b1;
            else if (tx.ready)
                tx_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                    if (q_valid)
                    begin
                        j_reg <= '0;
                        if (head.cls == CLS_ACK && ack_ok)
                            acked_reg <= head.ackno - 32'd1;
                    end
                ST_DUPSCAN:
                    priority if (scan_end)
                        j_reg <= '0;
                    else if (hit_dup)
                    begin
                        j_reg <= '0;
                        i_reg <= '0;
                    end
                    else
                        j_reg <= j_reg + CNT_W'(1);
                ST_FREESCAN:
                    priority if (scan_end)
                    begin
                        j_reg <= '0;
                        i_reg <= '0;
                    end
                    else if (slot_free)
                    begin
                        valid_reg[jx]  <= 1'b1;
                        j_reg <= '0;
                        i_reg <= '0;
                    end
                    else
                        j_reg <= j_reg + CNT_W'(1);
                ST_REL:
                begin
                    if (rel_emit)
                    begin
                        deliv_reg     <= deliv_reg + 32'd1;
                        valid_reg[jx] <= 1'b0;
                        if (deliver_res.eof)
                            eof_reg <= 1'b1;
                    end
                    if (rel_adv)
                    begin
                        if (j_reg == w - CNT_W'(1))
                        begin
                            j_reg <= '0;
                            i_reg <= i_reg + CNT_W'(1);
                        end
                        else
                            j_reg <= j_reg + CNT_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload registers and slot memory, no reset.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            seq_reg   <= head.seq;
            len_reg   <= head.len;
            space_reg <= head.space;
            pend_reg  <= idle_res;
        end
        if (state_reg == ST_DUPSCAN && !scan_end && hit_dup)
            pend_reg <= scan_res;
        if (state_reg == ST_FREESCAN)
        begin
            if (scan_end)
                pend_reg <= scan_res;
            else if (slot_free)
            begin
                seqno_mem[jx] <= seq_reg;
                len_mem[jx]   <= len_reg;
                pend_reg      <= scan_res;
            end
        end
        if (rel_emit)
        begin
            pend_reg  <= deliver_res;
            space_reg <= space_reg - SPACE_W'(cur_plen);
        end
        if (rel_emit || flush)
            tx_reg <= tx_load;
    end

    assign tx.valid          = tx_valid_reg;
    assign tx.kind           = tx_reg.kind;
    assign tx.slot           = tx_reg.slot;
    assign tx.value          = tx_reg.value;
    assign tx.payload_length = tx_reg.plen;
    assign tx.end_of_file    = tx_reg.eof;
    assign tx.last           = tx_reg.last;

endmodule

>>> hdl/sliding_window_receive_engine.sv
// Top level of the sliding window receive engine: front end, command queue and back end.
// A rejected header or an ack item passes through the command queue, the idle state and
// the flush state before its result is offered. For new in-window data the effective
// window is searched for a repeat, a free slot and in-order release, then the final
// result handed over; the single back end scans one slot a cycle unless output stalls.
// Reset (rst_n, asynchronous, active low) empties the queue and output, clears all slot
// valid bits, the acked count, delivered sequence number and end of file, window = 8.
module sliding_window_receive_engine #(
    parameter int WINDOW_MAX = swre_pkg::WINDOW_MAX_DEF,
    parameter int PACKET_MAX = swre_pkg::PACKET_MAX_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    swre_rx_if.sink   rx,
    swre_tx_if.source tx,
    swre_cfg_if.sink  cfg
);
    import swre_pkg::*;

    // Window reg set directly; user keeps configuration to idle, not enforced here.
    logic [WIN_W-1:0] window_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_size_reg <= WINDOW_RESET;
        else if (cfg.valid)
            window_size_reg <= cfg.window_size;
    end

    assign cfg.ready = 1'b1;

    // The front end classifies each header item and pushes a command.
    cmd_t       push_cmd, head;
    logic       push, pop, q_valid, q_full;
    logic [1:0] q_count;

    swre_front #(.PACKET_MAX(PACKET_MAX)) u_front (
        .rx     (rx),
        .q_full (q_full),
        .push   (push),
        .cmd    (push_cmd)
    );

    swre_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .head      (head),
        .not_empty (q_valid),
        .full      (q_full),
        .count     (q_count)
    );

    // The back end owns all protocol state and produces every result item.
    swre_back #(.WINDOW_MAX(WINDOW_MAX)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .window_size (window_size_reg),
        .head        (head),
        .q_valid     (q_valid),
        .pop         (pop),
        .tx          (tx)
    );

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= 2'd2)
        else $error("command queue overflow");

    a_queue_push: assert property (@(posedge clk) disable iff (!rst_n)
        (rx.valid && rx.ready && !pop) |=> (q_count == $past(q_count) + 2'd1))
        else $error("accepted item not queued");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (tx.valid && (tx.kind == KIND_REJECT || tx.kind == KIND_ACK_OK ||
                      tx.kind == KIND_ACK_DROP || tx.kind == KIND_DUP ||
                      tx.kind == KIND_BEYOND)) |-> tx.last)
        else $error("single-result item without last");

endmodule

>>> dv/sliding_window_receive_engine_tb.sv
// Self-checking testbench for the sliding window receive engine.
module sliding_window_receive_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import swre_pkg::*;

    // Longest quiet stretch that a correct block can show: a full window search and
    // release scan at W = 32, a long receiver stall, and the settle time before a register
    // write, taken several times over.
    localparam int SETTLE_CYCLES   = 1200;
    localparam int HOLD_CYCLES     = 300;
    localparam int WATCHDOG_CYCLES = 20000;
    localparam int PHASE_ITEMS     = 72;

    typedef struct {
        logic [FLEN_W-1:0]  rlen;
        logic [FLEN_W-1:0]  alen;
        logic               ck;
        logic [SEQ_W-1:0]   seq;
        logic [SEQ_W-1:0]   ackno;
        logic [SPACE_W-1:0] space;
        bit                 typed;   // expected result written into the table
        res_t               res;     // the one expected result when typed is set
    } hdr_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    swre_rx_if  rx_ch();
    swre_tx_if  tx_ch();
    swre_cfg_if cfg_ch();

    sliding_window_receive_engine dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch.sink),
        .tx    (tx_ch.source),
        .cfg   (cfg_ch.sink)
    );

    always #1 clk = ~clk;

    // Mirror of the block's state, advanced as each item and register write is accepted.
    logic [WIN_W-1:0]  win_reg;
    logic [SEQ_W-1:0]  acked_cnt;
    logic [SEQ_W-1:0]  dlv_seq;
    bit                eof_seen;
    bit                buf_valid [WINDOW_MAX_DEF];
    logic [SEQ_W-1:0]  buf_seq   [WINDOW_MAX_DEF];
    logic [LEN_W-1:0]  buf_len   [WINDOW_MAX_DEF];

    // Results still owed by the block, oldest first.
    res_t owed_results[$];

    int errors      = 0;
    int n_items     = 0;
    int n_results   = 0;
    int n_delivered = 0;
    int n_eof       = 0;
    int n_no_room   = 0;
    int quiet_cycles = 0;

    bit calm      = 1'b0;   // when set, neither side idles
    bit hold_req  = 1'b0;   // asks the receiver for one long stall

    function automatic int unsigned eff_window();
        if (win_reg == 0)
            return 1;
        if (win_reg > WINDOW_MAX_DEF)
            return WINDOW_MAX_DEF;
        return 32'(win_reg);
    endfunction

    function automatic res_t mk_res(kind_t k, int unsigned slot, logic [SEQ_W-1:0] value,
                                    int unsigned plen, bit eof);
        res_t r;
        r.kind  = k;
        r.slot  = slot[SLOT_W-1:0];
        r.value = value;
        r.plen  = plen[PLEN_W-1:0];
        r.eof   = eof;
        r.last  = 1'b0;
        return r;
    endfunction

    // Works out the results of one accepted header and updates the mirror state.
    function automatic void predict_header(input hdr_t h, output res_t outq[$]);
        int unsigned w;
        int unsigned space;
        int unsigned len;
        int unsigned plen;
        logic [SEQ_W-1:0] d;
        logic [SEQ_W-1:0] top;
        bit done;
        bit stop;
        w = eff_window();
        outq = {};
        if (h.rlen != h.alen || h.alen < ACK_LEN || h.alen > PACKET_MAX_DEF ||
            (h.alen > ACK_LEN && h.alen < HDR_LEN) || !h.ck) begin
            outq.push_back(mk_res(KIND_REJECT, 0, '0, 0, 1'b0));
        end
        else if (h.alen == ACK_LEN) begin
            // The ack must move the count forward by 0..window, as a wrapped difference.
            d = h.ackno - acked_cnt - 1;
            if (!d[SEQ_W-1] && d <= w) begin
                acked_cnt = h.ackno - 1;
                outq.push_back(mk_res(KIND_ACK_OK, 0, acked_cnt, 0, 1'b0));
            end
            else
                outq.push_back(mk_res(KIND_ACK_DROP, 0, acked_cnt, 0, 1'b0));
        end
        else if (h.seq <= dlv_seq) begin
            outq.push_back(mk_res(KIND_DUP, 0, dlv_seq + 1, 0, 1'b0));
        end
        else begin
            top = dlv_seq + w;
            if (h.seq > top) begin
                outq.push_back(mk_res(KIND_BEYOND, 0, '0, 0, 1'b0));
            end
            else begin
                done = 1'b0;
                for (int i = 0; i < w && !done; i++)
                    if (buf_valid[i] && buf_seq[i] == h.seq) begin
                        outq.push_back(mk_res(KIND_NOT_STORED, i, '0, 0, 1'b0));
                        done = 1'b1;
                    end
                for (int i = 0; i < w && !done; i++)
                    if (!buf_valid[i]) begin
                        buf_valid[i] = 1'b1;
                        buf_seq[i]   = h.seq;
                        buf_len[i]   = h.alen[LEN_W-1:0];
                        outq.push_back(mk_res(KIND_STORED, i, '0, 0, 1'b0));
                        done = 1'b1;
                    end
                if (!done)
                    outq.push_back(mk_res(KIND_NOT_STORED, 0, '0, 0, 1'b0));
                // In-order release while the output buffer has room for the whole packet.
                space = 32'(h.space);
                stop  = eof_seen;
                for (int i = 0; i < w && !stop; i++)
                    for (int j = 0; j < w && !stop; j++)
                        if (buf_valid[j] && buf_seq[j] - dlv_seq == 1) begin
                            len  = 32'(buf_len[j]);
                            plen = (len >= HDR_LEN) ? len - HDR_LEN : 0;
                            if (space <= len)
                                stop = 1'b1;
                            else begin
                                space -= plen;
                                outq.push_back(mk_res(KIND_DELIVER, j, buf_seq[j] + 1, plen,
                                                      len == HDR_LEN));
                                dlv_seq++;
                                buf_valid[j] = 1'b0;
                                if (len == HDR_LEN) begin
                                    eof_seen = 1'b1;
                                    stop = 1'b1;
                                end
                            end
                        end
            end
        end
        outq[outq.size()-1].last = 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        errors++;
    endtask

    // Offers one header after a gap and waits until the block takes it.
    task automatic send_header(input hdr_t h);
        int gap;
        res_t outq[$];
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_ch.valid             <= 1'b1;
        rx_ch.received_length   <= h.rlen;
        rx_ch.advertised_length <= h.alen;
        rx_ch.checksum_ok       <= h.ck;
        rx_ch.sequence_number   <= h.seq;
        rx_ch.ack_number        <= h.ackno;
        rx_ch.output_space      <= h.space;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        predict_header(h, outq);
        if (h.typed) begin
            if (outq.size() != 1 || outq[0] != h.res)
                report_mismatch("typed expectation disagrees with prediction");
            owed_results.push_back(h.res);
        end
        else
            foreach (outq[i])
                owed_results.push_back(outq[i]);
        n_items++;
    endtask

    // Lets the block finish: all owed results in, then the longest scan allowed to end.
    task automatic drain();
        rx_ch.valid <= 1'b0;
        wait (owed_results.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input logic [WIN_W-1:0] w);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.window_size <= w;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        win_reg = w;
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic hdr_t row(int unsigned rl, int unsigned al, bit ck,
                                 logic [SEQ_W-1:0] seq, logic [SEQ_W-1:0] ackno,
                                 int unsigned space);
        hdr_t h;
        h.rlen  = rl[FLEN_W-1:0];
        h.alen  = al[FLEN_W-1:0];
        h.ck    = ck;
        h.seq   = seq;
        h.ackno = ackno;
        h.space = space[SPACE_W-1:0];
        h.typed = 1'b0;
        h.res   = '0;
        return h;
    endfunction

    function automatic hdr_t typed_row(hdr_t h, kind_t k, logic [SEQ_W-1:0] value);
        h.typed = 1'b1;
        h.res   = mk_res(k, 0, value, 0, 1'b0);
        h.res.last = 1'b1;
        return h;
    endfunction

    // Draws one header. Most are well-formed data and acks placed around the
    // live window; the rest are malformed, duplicate or far-off headers.
    function automatic hdr_t random_header(bit eof_ok);
        hdr_t h;
        int unsigned pick;
        int unsigned w;
        int unsigned len;
        w = eff_window();
        h = row($urandom_range(0, 65535), $urandom_range(0, 65535), 1'b1,
                $urandom, $urandom, $urandom_range(0, 65535));
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            // Malformed header: random lengths, or a near miss on one rule.
            case ($urandom_range(0, 3))
                0: h.ck = 1'($urandom_range(0, 1));
                1: begin h.alen = FLEN_W'($urandom_range(9, 11)); h.rlen = h.alen; end
                2: begin h.alen = FLEN_W'($urandom_range(513, 65535)); h.rlen = h.alen; end
                default:
                begin
                    h.alen = FLEN_W'($urandom_range(12, 512));
                    h.rlen = h.alen;
                    h.ck   = 1'b0;
                end
            endcase
        end
        else if (pick < 22) begin
            h.alen = ACK_LEN;
            h.rlen = ACK_LEN;
            if ($urandom_range(0, 9) < 7)
                h.ackno = acked_cnt + 1 + $urandom_range(0, w + 1);
        end
        else begin
            if ($urandom_range(0, 9) < 7)
                len = $urandom_range(13, 80);
            else
                len = $urandom_range(12, 512);
            if (len == HDR_LEN && !(eof_ok && $urandom_range(0, 19) == 0))
                len = 13;
            h.alen = FLEN_W'(len);
            h.rlen = h.alen;
            if (pick < 28)
                h.seq = dlv_seq - $urandom_range(0, 3);
            else if (pick < 32)
                ; // far-off sequence number, left fully random
            else
                h.seq = dlv_seq + 1 + $urandom_range(0, w);
            if ($urandom_range(0, 9) < 7)
                h.space = SPACE_W'($urandom_range(600, 65535));
        end
        return h;
    endfunction

    // Receiver: random stalls per item, plus one long hold-off when asked.
    initial begin
        int gap;
        tx_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            gap = calm ? 0 : $urandom_range(0, 3);
            if (hold_req) begin
                tx_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (gap > 0) begin
                tx_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            tx_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(tx_ch.valid && tx_ch.ready));
        end
    end

    // Result checker: each accepted result item against the oldest owed result.
    always @(posedge clk) begin
        res_t want;
        if (rst_n && tx_ch.valid && tx_ch.ready) begin
            n_results++;
            if (owed_results.size() == 0)
                report_mismatch($sformatf("result with nothing owed, kind %0d", tx_ch.kind));
            else begin
                want = owed_results.pop_front();
                if (kind_t'(tx_ch.kind) != want.kind)
                    report_mismatch($sformatf("kind %0d, wanted %0d", tx_ch.kind, want.kind));
                if (tx_ch.slot != want.slot)
                    report_mismatch($sformatf("slot %0d, wanted %0d", tx_ch.slot, want.slot));
                if (tx_ch.value != want.value)
                    report_mismatch($sformatf("value %0h, wanted %0h", tx_ch.value, want.value));
                if (tx_ch.payload_length != want.plen)
                    report_mismatch($sformatf("payload %0d, wanted %0d",
                                              tx_ch.payload_length, want.plen));
                if (tx_ch.end_of_file != want.eof)
                    report_mismatch("end_of_file flag differs");
                if (tx_ch.last != want.last)
                    report_mismatch("last flag differs");
                if (want.kind == KIND_DELIVER)
                    n_delivered++;
                if (want.eof)
                    n_eof++;
                if (want.kind == KIND_NOT_STORED)
                    n_no_room++;
            end
        end
    end

    // Watchdog: ends the run when nothing moves on any channel for too long.
    always @(posedge clk) begin
        if ((rx_ch.valid && rx_ch.ready) || (tx_ch.valid && tx_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("[sliding_window_receive_engine] ERROR");
            $finish;
        end
    end

    // Main sequence: reset, directed table, then random phases at several windows.
    initial begin
        hdr_t directed[$];
        hdr_t h;
        logic [WIN_W-1:0] windows[6] = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd5, 6'd8};

        rx_ch.valid             <= 1'b0;
        rx_ch.received_length   <= '0;
        rx_ch.advertised_length <= '0;
        rx_ch.checksum_ok       <= 1'b0;
        rx_ch.sequence_number   <= '0;
        rx_ch.ack_number        <= '0;
        rx_ch.output_space      <= '0;
        cfg_ch.valid            <= 1'b0;
        cfg_ch.window_size      <= '0;

        win_reg   = WINDOW_RESET;
        acked_cnt = '0;
        dlv_seq   = '0;
        eof_seen  = 1'b0;
        foreach (buf_valid[i])
        begin
            buf_valid[i] = 1'b0;
            buf_seq[i]   = '0;
            buf_len[i]   = '0;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Header checks: length mismatch, too short, the 9..11 gap, too long, bad checksum.
        directed.push_back(typed_row(row(0, 65535, 1, 0, 0, 0), KIND_REJECT, 0));
        directed.push_back(typed_row(row(7, 7, 1, 1, 1, 65535), KIND_REJECT, 0));
        directed.push_back(typed_row(row(9, 9, 1, 1, 1, 65535), KIND_REJECT, 0));
        directed.push_back(typed_row(row(10, 10, 1, 1, 1, 65535), KIND_REJECT, 0));
        directed.push_back(typed_row(row(11, 11, 1, 1, 1, 65535), KIND_REJECT, 0));
        directed.push_back(typed_row(row(513, 513, 1, 1, 1, 65535), KIND_REJECT, 0));
        directed.push_back(typed_row(row(100, 100, 0, 1, 1, 65535), KIND_REJECT, 0));
        directed.push_back(typed_row(row(65535, 65535, 1, '1, '1, 65535), KIND_REJECT, 0));
        // Acks at reset: behind the count, at its bottom, at the window edge, past it.
        directed.push_back(typed_row(row(8, 8, 1, 0, 0, 0), KIND_ACK_DROP, 0));
        directed.push_back(typed_row(row(8, 8, 1, 0, 1, 0), KIND_ACK_OK, 0));
        directed.push_back(typed_row(row(8, 8, 1, 0, 9, 0), KIND_ACK_OK, 8));
        directed.push_back(typed_row(row(8, 8, 1, 0, 18, 0), KIND_ACK_DROP, 8));
        // Data: duplicate, just past the window, out of order, repeat, in-order release.
        directed.push_back(typed_row(row(100, 100, 1, 0, 0, 0), KIND_DUP, 1));
        directed.push_back(typed_row(row(100, 100, 1, 9, 0, 65535), KIND_BEYOND, 0));
        directed.push_back(row(100, 100, 1, 2, 0, 0));
        directed.push_back(row(100, 100, 1, 2, 0, 0));
        directed.push_back(row(512, 512, 1, 1, 0, 65535));
        // Space equal to the packet length holds it back; one byte more lets it go.
        directed.push_back(row(100, 100, 1, 3, 0, 100));
        directed.push_back(row(50, 50, 1, 4, 0, 101));
        directed.push_back(row(13, 13, 1, 5, 0, 65535));

        foreach (directed[i])
            send_header(directed[i]);

        for (int p = 0; p < 6; p++) begin
            drain();
            write_window(windows[p]);
            calm = (p == 2);
            if (p == 1)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 3 && n == PHASE_ITEMS / 2) begin
                    rx_ch.valid <= 1'b0;
                    wait (owed_results.size() == 0);
                    @(posedge clk);
                end
                h = random_header(p == 5 && n > PHASE_ITEMS / 2);
                send_header(h);
            end
        end

        drain();

        $display("covered %0d headers and %0d results at windows 8, 1, 32, 0, 63 and 5",
                 n_items, n_results);
        $display("with %0d deliveries, %0d end markers and %0d not-stored cases",
                 n_delivered, n_eof, n_no_room);
        if (errors == 0 && owed_results.size() == 0)
            $display("[sliding_window_receive_engine] OK");
        else begin
            if (owed_results.size() != 0)
                $display("%0d results never arrived", owed_results.size());
            $display("[sliding_window_receive_engine] ERROR");
        end
        $finish;
    end

endmodule

>>> sliding_window_receive_engine.f
hdl/swre_pkg.sv
hdl/swre_if.sv
hdl/swre_front.sv
hdl/swre_queue.sv
hdl/swre_back.sv
hdl/sliding_window_receive_engine.sv
dv/sliding_window_receive_engine_tb.sv
